// File: design/bsea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binned squared-error accumulator package
// Shared widths, command and register codes, reset values and the payload
// types of the input and result channels.
// ----------------------------------------------------------------------------
package bsea_pkg;

  localparam int TRACK_BINS_DEF   = 64;
  localparam int NUM_SPD_BINS_DEF = 64;

  localparam int SPD_W      = 16;
  localparam int DIR_W      = 16;
  localparam int BIN_W      = 6;
  localparam int HIT_W      = 7;
  localparam int SUM_W      = 64;
  localparam int CNT_W      = 32;
  localparam int ERR_W      = 32;
  localparam int CMD_W      = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BCNT_W     = 7;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Read axis
  localparam logic AXIS_TRACK = 1'b0;
  localparam logic AXIS_SPEED = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_LOW_SPEED   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_SPEED  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DIR_ERR = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BIN_WIDTH   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_BIN_COUNT   = 3'd4;

  // Configuration reset values
  localparam logic [SPD_W-1:0]  LOW_SPEED_RST   = 16'd0;
  localparam logic [SPD_W-1:0]  HIGH_SPEED_RST  = 16'd65535;
  localparam logic [DIR_W-1:0]  MAX_DIR_ERR_RST = 16'd32768;
  localparam logic [SPD_W-1:0]  BIN_WIDTH_RST   = 16'd100;
  localparam logic [BCNT_W-1:0] BIN_COUNT_RST   = 7'd64;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             axis;
    logic [BIN_W-1:0] bin_index;
    logic [SPD_W-1:0] true_speed;
    logic [DIR_W-1:0] true_dir;
    logic [SPD_W-1:0] nearest_speed;
    logic [DIR_W-1:0] nearest_dir;
    logic             selected_valid;
    logic [SPD_W-1:0] selected_speed;
    logic [DIR_W-1:0] selected_dir;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] near_speed_sum;
    logic [CNT_W-1:0] near_speed_count;
    logic [SUM_W-1:0] near_dir_sum;
    logic [CNT_W-1:0] near_dir_count;
    logic [SUM_W-1:0] sel_speed_sum;
    logic [CNT_W-1:0] sel_speed_count;
    logic [SUM_W-1:0] sel_dir_sum;
    logic [CNT_W-1:0] sel_dir_count;
    logic [HIT_W-1:0] speed_bin_hit;
    logic             in_window;
  } out_item_t;

endpackage

// File: design/bsea_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One transaction moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface bsea_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (
    output valid,
    output data,
    input  ready
  );

  modport sink (
    input  valid,
    input  data,
    output ready
  );

endinterface

// File: design/binned_squared_error_accumulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binned squared-error accumulator core
// Accumulates squared speed and direction errors with counts into track and
// speed bins; reads back one bin and clears all stores on command.
// ----------------------------------------------------------------------------
// An accepted transaction runs through these steps: an accumulate through the bit-serial
// speed-bin divider, the binning state and a read-modify-write of four entries per store,
// then the output load; a read through four entry reads; a clear through a walk over every
// store address; an unused command straight to the output load. One transaction is in work
// at a time; the next is taken the cycle after the output register loads. Reset clears the stores.
module binned_squared_error_accumulator_core
  import bsea_pkg::*;
#(
  parameter int TRACK_BINS   = TRACK_BINS_DEF,
  parameter int NUM_SPD_BINS = NUM_SPD_BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bsea_stream_if.sink           in_ch,
  bsea_stream_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TDEPTH    = 4 * TRACK_BINS;
  localparam int SDEPTH    = 4 * NUM_SPD_BINS;
  localparam int TA_W      = $clog2(TDEPTH);
  localparam int SA_W      = $clog2(SDEPTH);
  localparam int SB_W      = $clog2(NUM_SPD_BINS + 1);
  localparam int MAX_DEPTH = (TDEPTH > SDEPTH) ? TDEPTH : SDEPTH;
  localparam int CLR_W     = $clog2(MAX_DEPTH);
  localparam int DIV_STEPS = SPD_W;
  localparam int DC_W      = $clog2(DIV_STEPS);
  localparam int OP_W      = SPD_W + 1;

  localparam logic [1:0] TERM_NEAR_SPD = 2'd0;
  localparam logic [1:0] TERM_NEAR_DIR = 2'd1;
  localparam logic [1:0] TERM_SEL_SPD  = 2'd2;
  localparam logic [1:0] TERM_SEL_DIR  = 2'd3;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_BIN, S_MRD, S_MWR, S_DONE
  } state_t;

  // Configuration registers
  logic [SPD_W-1:0]  low_speed_r, high_speed_r, bin_width_r;
  logic [DIR_W-1:0]  max_dir_r;
  logic [BCNT_W-1:0] bin_count_r;

  // Sequencer and datapath registers
  state_t             state_r, state_nxt;
  logic [CLR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic               clr_resp_r, clr_resp_nxt;
  in_item_t           item_r, item_nxt;
  logic [DC_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic [SPD_W:0]     rem_r, rem_nxt;
  logic [SPD_W-1:0]   quo_r, quo_nxt;
  logic [ERR_W-1:0]   err_r [4];
  logic [ERR_W-1:0]   err_nxt [4];
  logic               trk_en_r, trk_en_nxt;
  logic               spd_en_r, spd_en_nxt;
  logic [SB_W-1:0]    sb_r, sb_nxt;
  logic [1:0]         term_r, term_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // Stores
  entry_t             t_mem [TDEPTH];
  entry_t             s_mem [SDEPTH];
  entry_t             t_rd_r, s_rd_r;
  logic [TA_W-1:0]    t_addr;
  logic [SA_W-1:0]    s_addr;
  logic               t_we, s_we;
  entry_t             t_wdata, s_wdata;

  // Shared datapath signals
  logic [OP_W-1:0]    mult_op;
  logic [2*OP_W-1:0]  prod;
  logic [SPD_W:0]     div_trial;
  logic               div_ge;
  logic               sel_ok;
  logic               term_en;
  logic               win;
  logic               spd_ok;
  logic               load_out;
  entry_t             rd_sel;

  function automatic logic [SPD_W-1:0] spd_diff(input logic [SPD_W-1:0] a,
                                                input logic [SPD_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Magnitude of the wrapped signed angle difference, 0 to half a turn.
  function automatic logic [DIR_W:0] dir_mag(input logic [DIR_W-1:0] other,
                                             input logic [DIR_W-1:0] truth);
    logic [DIR_W-1:0] d;
    d = other - truth;
    return d[DIR_W-1] ? ((DIR_W+1)'(1) << DIR_W) - {1'b0, d} : {1'b0, d};
  endfunction

  function automatic entry_t sat_add(input entry_t e, input logic [ERR_W-1:0] v);
    logic [SUM_W:0] s;
    entry_t         r;
    s     = {1'b0, e.sum} + (SUM_W+1)'(v);
    r.sum = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    r.cnt = (&e.cnt) ? e.cnt : e.cnt + 1'b1;
    return r;
  endfunction

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // The multiplier squares one error term per divider step during the first
  // four steps.
  always_comb begin
    unique case (div_cnt_r[1:0])
      TERM_NEAR_SPD: mult_op = {1'b0, spd_diff(item_r.nearest_speed, item_r.true_speed)};
      TERM_NEAR_DIR: mult_op = dir_mag(item_r.nearest_dir, item_r.true_dir);
      TERM_SEL_SPD:  mult_op = {1'b0, spd_diff(item_r.selected_speed, item_r.true_speed)};
      TERM_SEL_DIR:  mult_op = dir_mag(item_r.selected_dir, item_r.true_dir);
    endcase
  end

  assign prod      = mult_op * mult_op;
  assign div_trial = {rem_r[SPD_W-1:0], quo_r[SPD_W-1]};
  assign div_ge    = (div_trial >= {1'b0, bin_width_r});
  assign sel_ok    = (dir_mag(item_r.selected_dir, item_r.true_dir) < {1'b0, max_dir_r});
  assign term_en   = (term_r == TERM_NEAR_SPD) || (term_r == TERM_NEAR_DIR) ||
                     (item_r.selected_valid && ((term_r == TERM_SEL_SPD) || sel_ok));
  assign win       = (item_r.true_speed >= low_speed_r) && (item_r.true_speed < high_speed_r);
  assign spd_ok    = (bin_width_r != '0) && (32'(quo_r) < 32'(bin_count_r)) &&
                     (32'(quo_r) < NUM_SPD_BINS);
  assign rd_sel    = trk_en_r ? t_rd_r : s_rd_r;

  assign t_addr = (state_r == S_CLEAR) ? clr_cnt_r[TA_W-1:0] :
                  TA_W'(32'(item_r.bin_index) * 4 + 32'(term_r));
  assign s_addr = (state_r == S_CLEAR) ? clr_cnt_r[SA_W-1:0] :
                  SA_W'(32'(sb_r) * 4 + 32'(term_r));

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    clr_resp_nxt = clr_resp_r;
    item_nxt     = item_r;
    div_cnt_nxt  = div_cnt_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    err_nxt      = err_r;
    trk_en_nxt   = trk_en_r;
    spd_en_nxt   = spd_en_r;
    sb_nxt       = sb_r;
    term_nxt     = term_r;
    res_nxt      = res_r;
    t_we         = 1'b0;
    s_we         = 1'b0;
    t_wdata      = '0;
    s_wdata      = '0;
    load_out     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        t_we = (32'(clr_cnt_r) < TDEPTH);
        s_we = (32'(clr_cnt_r) < SDEPTH);
        if (32'(clr_cnt_r) == MAX_DEPTH - 1) begin
          clr_cnt_nxt  = '0;
          clr_resp_nxt = 1'b0;
          state_nxt    = clr_resp_r ? S_DONE : S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt    = in_ch.data;
          res_nxt     = '0;
          term_nxt    = TERM_NEAR_SPD;
          div_cnt_nxt = '0;
          rem_nxt     = '0;
          quo_nxt     = in_ch.data.true_speed;
          trk_en_nxt  = 1'b0;
          spd_en_nxt  = 1'b0;
          unique case (in_ch.data.cmd)
            CMD_ACC: state_nxt = S_DIV;
            CMD_READ: begin
              if (in_ch.data.axis == AXIS_TRACK && 32'(in_ch.data.bin_index) < TRACK_BINS) begin
                trk_en_nxt = 1'b1;
                state_nxt  = S_MRD;
              end else if (in_ch.data.axis == AXIS_SPEED &&
                           32'(in_ch.data.bin_index) < NUM_SPD_BINS) begin
                spd_en_nxt = 1'b1;
                sb_nxt     = SB_W'(in_ch.data.bin_index);
                state_nxt  = S_MRD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            CMD_CLEAR: begin
              clr_resp_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // Restoring division, one quotient bit per cycle, MSB first.
      S_DIV: begin
        rem_nxt = div_ge ? (div_trial - {1'b0, bin_width_r}) : div_trial;
        quo_nxt = {quo_r[SPD_W-2:0], div_ge};
        if (div_cnt_r[DC_W-1:2] == '0) begin
          err_nxt[div_cnt_r[1:0]] = prod[ERR_W-1:0];
        end
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DC_W'(DIV_STEPS - 1)) begin
          state_nxt = S_BIN;
        end
      end

      S_BIN: begin
        trk_en_nxt            = win && (32'(item_r.bin_index) < TRACK_BINS);
        spd_en_nxt            = spd_ok;
        sb_nxt                = spd_ok ? SB_W'(quo_r) : SB_W'(NUM_SPD_BINS);
        res_nxt.speed_bin_hit = HIT_W'(sb_nxt);
        res_nxt.in_window     = win;
        state_nxt             = S_MRD;
      end

      S_MRD: state_nxt = S_MWR;

      S_MWR: begin
        if (item_r.cmd == CMD_ACC) begin
          t_we    = trk_en_r && term_en;
          s_we    = spd_en_r && term_en;
          t_wdata = sat_add(t_rd_r, err_r[term_r]);
          s_wdata = sat_add(s_rd_r, err_r[term_r]);
        end else begin
          unique case (term_r)
            TERM_NEAR_SPD: begin
              res_nxt.near_speed_sum   = rd_sel.sum;
              res_nxt.near_speed_count = rd_sel.cnt;
            end
            TERM_NEAR_DIR: begin
              res_nxt.near_dir_sum   = rd_sel.sum;
              res_nxt.near_dir_count = rd_sel.cnt;
            end
            TERM_SEL_SPD: begin
              res_nxt.sel_speed_sum   = rd_sel.sum;
              res_nxt.sel_speed_count = rd_sel.cnt;
            end
            TERM_SEL_DIR: begin
              res_nxt.sel_dir_sum   = rd_sel.sum;
              res_nxt.sel_dir_count = rd_sel.cnt;
            end
          endcase
        end
        if (term_r == TERM_SEL_DIR) begin
          state_nxt = S_DONE;
        end else begin
          term_nxt  = term_r + 1'b1;
          state_nxt = S_MRD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_resp_r  <= clr_resp_nxt;
      out_valid_r <= out_valid_nxt;
      item_r      <= item_nxt;
      div_cnt_r   <= div_cnt_nxt;
      rem_r       <= rem_nxt;
      quo_r       <= quo_nxt;
      err_r       <= err_nxt;
      trk_en_r    <= trk_en_nxt;
      spd_en_r    <= spd_en_nxt;
      sb_r        <= sb_nxt;
      term_r      <= term_nxt;
      res_r       <= res_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_speed_r  <= LOW_SPEED_RST;
      high_speed_r <= HIGH_SPEED_RST;
      max_dir_r    <= MAX_DIR_ERR_RST;
      bin_width_r  <= BIN_WIDTH_RST;
      bin_count_r  <= BIN_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LOW_SPEED:   low_speed_r  <= cfg_wdata[SPD_W-1:0];
        CFG_HIGH_SPEED:  high_speed_r <= cfg_wdata[SPD_W-1:0];
        CFG_MAX_DIR_ERR: max_dir_r    <= cfg_wdata[DIR_W-1:0];
        CFG_BIN_WIDTH:   bin_width_r  <= cfg_wdata[SPD_W-1:0];
        CFG_BIN_COUNT:   bin_count_r  <= cfg_wdata[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      t_mem[t_addr] <= t_wdata;
    end
    t_rd_r <= t_mem[t_addr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      s_mem[s_addr] <= s_wdata;
    end
    s_rd_r <= s_mem[s_addr];
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start work");

  a_trk_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (t_we && state_r != S_CLEAR) |-> (trk_en_r && item_r.cmd == CMD_ACC))
    else $error("track store written outside an enabled accumulate");

  a_spd_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (s_we && state_r != S_CLEAR) |-> (spd_en_r && item_r.cmd == CMD_ACC &&
                                      32'(sb_r) < NUM_SPD_BINS))
    else $error("speed store written outside an enabled accumulate");

  a_last_term_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MWR && term_r == TERM_SEL_DIR) |=> (state_r == S_DONE))
    else $error("entry walk did not finish after the fourth entry");

endmodule
